FILE: sv/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants and types for the lidar packet decoder.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned PKT_LEN     = 22;
  localparam int unsigned PKT_WORDS   = PKT_LEN / 2;
  localparam int unsigned RAM_DEPTH   = 2 * PKT_WORDS;
  localparam int unsigned RAM_WIDTH   = 16;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);
  localparam int unsigned READINGS    = 4;

  localparam logic [7:0]  START_BYTE   = 8'hFA;
  localparam logic [7:0]  INDEX_LOW    = 8'hA0;
  localparam logic [7:0]  INDEX_HIGH   = 8'hF9;
  localparam logic [13:0] BAD_DISTANCE = 14'd9999;
  localparam logic [4:0]  CNT_SUM_LAST = 5'd20;
  localparam logic [4:0]  CNT_LAST     = 5'(PKT_LEN);
  localparam logic [4:0]  CNT_INDEX    = 5'd2;
  localparam logic [4:0]  CNT_SPEED    = 5'd4;

  // running checksum never exceeds ten doublings of a 16-bit word
  localparam int unsigned SUM_W = 26;

  typedef logic [RAM_AW-1:0] ram_addr_t;
  typedef logic [RAM_WIDTH-1:0] ram_word_t;

endpackage

FILE: sv/lpd_ram.sv
// ----------------------------------------------------------------------------
// lpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/lidar_packet_decoder.sv
// ----------------------------------------------------------------------------
// lidar_packet_decoder
// Hunts for the start byte, gathers a 22-byte packet into RAM as words,
// checks the folded checksum and index, then reads four readings back.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | dir
//  ----------+-------------------------------------------+-----
//  input     | in_valid, in_ready, in_rx_byte            | in
//  result    | out_valid, out_ready, out_angle_deg ...   | out
//
//  One input beat is taken per cycle while in_ready is high. A good packet
//  yields four result beats, one per cycle unless out_ready stalls them, read
//  from the RAM's single read port in the cycle after issue. The RAM holds
//  two packet banks: a new packet fills one bank while the previous one is
//  read out; only the last byte of a packet waits while a readout is still
//  busy. Reset is synchronous and clears all control state; RAM contents are
//  left as they are. Output stalls back up through a one-deep read stage into
//  the readout counter.
module lidar_packet_decoder
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_angle_deg,
  output logic [13:0] out_distance_mm,
  output logic        out_invalid_flag,
  output logic        out_warning_flag,
  output logic [9:0]  out_speed_rpm,
  output logic        out_last_reading
);

  // gather state
  logic             in_packet_r, in_packet_nxt;
  logic [4:0]       byte_count_r, byte_count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [9:0]       speed_r, speed_nxt;
  logic             wr_bank_r, wr_bank_nxt;

  // readout state
  logic             ro_bank_r, ro_bank_nxt;
  logic [6:0]       ro_base_r, ro_base_nxt;
  logic [9:0]       ro_speed_r, ro_speed_nxt;
  logic [2:0]       rd_left_r, rd_left_nxt;
  logic [1:0]       rd_num_r, rd_num_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [1:0]       dnum_r, dnum_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [8:0]       angle_r;
  logic [13:0]      dist_r;
  logic             inv_r, warn_r, last_r;
  logic [9:0]       ospeed_r;

  logic             in_acc, rd_busy, load, issue;
  logic [4:0]       n;
  logic [15:0]      word;
  logic [14:0]      calc;
  logic             pkt_ok;
  logic [3:0]       wr_word;
  logic [3:0]       rd_word;
  ram_addr_t        wr_addr, rd_addr;
  logic             wr_en;
  ram_word_t        rd_data;

  assign rd_busy  = (rd_left_r != 3'd0) || rd_pend_r;
  // last byte of a packet waits until the other bank is free again
  assign in_ready = !(in_packet_r && (byte_count_r == CNT_LAST - 5'd1) && rd_busy);
  assign in_acc   = in_valid && in_ready;

  assign n    = byte_count_r + 5'd1;
  assign word = {in_rx_byte, lo_r};
  assign calc = 15'(({4'd0, sum_r[14:0]} + {8'd0, sum_r[SUM_W-1:15]}));
  assign pkt_ok = (word == {1'b0, calc}) && (idx_r >= INDEX_LOW) && (idx_r <= INDEX_HIGH);

  // word write into the gather bank on every even byte count
  assign wr_word = n[4:1] - 4'd1;
  assign wr_en   = in_acc && in_packet_r && !n[0];
  assign wr_addr = wr_bank_r ? RAM_AW'(PKT_WORDS) + RAM_AW'(wr_word) : RAM_AW'(wr_word);

  // gather, checksum fold and hand-off of a good packet to the readout
  always_comb begin
    in_packet_nxt  = in_packet_r;
    byte_count_nxt = byte_count_r;
    sum_nxt        = sum_r;
    lo_nxt         = lo_r;
    idx_nxt        = idx_r;
    speed_nxt      = speed_r;
    wr_bank_nxt    = wr_bank_r;
    ro_bank_nxt    = ro_bank_r;
    ro_base_nxt    = ro_base_r;
    ro_speed_nxt   = ro_speed_r;
    rd_left_nxt    = rd_left_r;
    if (in_acc) begin
      if (!in_packet_r) begin
        if (in_rx_byte == START_BYTE) begin
          in_packet_nxt  = 1'b1;
          byte_count_nxt = 5'd1;
          sum_nxt        = '0;
          lo_nxt         = in_rx_byte;
          wr_bank_nxt    = !wr_bank_r;
        end
      end else begin
        byte_count_nxt = n;
        if (n[0]) begin
          lo_nxt = in_rx_byte;
        end else if (n <= CNT_SUM_LAST) begin
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0} + SUM_W'(word);
        end
        if (n == CNT_INDEX) begin
          idx_nxt = in_rx_byte;
        end
        if (n == CNT_SPEED) begin
          speed_nxt = word[15:6];
        end
        if (n == CNT_LAST) begin
          in_packet_nxt  = 1'b0;
          byte_count_nxt = '0;
          if (pkt_ok) begin
            ro_bank_nxt  = wr_bank_r;
            ro_base_nxt  = 7'(idx_r - INDEX_LOW);
            ro_speed_nxt = speed_r;
            rd_left_nxt  = 3'(READINGS);
          end
        end
      end
    end
    if (issue) begin
      rd_left_nxt = rd_left_r - 3'd1;
    end
  end

  // readout: one read in flight, drained into the output register
  assign load  = rd_pend_r && (!out_valid_r || out_ready);
  assign issue = (rd_left_r != 3'd0) && (!rd_pend_r || load);

  assign rd_word = {1'b0, rd_num_r, 1'b0} + 4'd2;
  assign rd_addr = ro_bank_r ? RAM_AW'(PKT_WORDS) + RAM_AW'(rd_word) : RAM_AW'(rd_word);

  always_comb begin
    rd_num_nxt    = rd_num_r;
    dnum_nxt      = dnum_r;
    rd_pend_nxt   = issue || (rd_pend_r && !load);
    out_valid_nxt = load || (out_valid_r && !out_ready);
    if (issue) begin
      rd_num_nxt = rd_num_r + 2'd1;
      dnum_nxt   = rd_num_r;
    end
    if (rd_left_nxt == 3'(READINGS) && rd_left_r == 3'd0) begin
      rd_num_nxt = '0;
    end
  end

  lpd_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      byte_count_r <= '0;
      sum_r        <= '0;
      wr_bank_r    <= 1'b0;
      rd_left_r    <= '0;
      rd_num_r     <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_packet_r  <= in_packet_nxt;
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      wr_bank_r    <= wr_bank_nxt;
      rd_left_r    <= rd_left_nxt;
      rd_num_r     <= rd_num_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    idx_r      <= idx_nxt;
    speed_r    <= speed_nxt;
    ro_bank_r  <= ro_bank_nxt;
    ro_base_r  <= ro_base_nxt;
    ro_speed_r <= ro_speed_nxt;
    dnum_r     <= dnum_nxt;
    if (load) begin
      angle_r  <= {ro_base_r, dnum_r};
      inv_r    <= rd_data[15];
      warn_r   <= rd_data[14];
      dist_r   <= rd_data[15] ? BAD_DISTANCE : rd_data[13:0];
      ospeed_r <= ro_speed_r;
      last_r   <= (dnum_r == 2'(READINGS - 1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_angle_deg    = angle_r;
  assign out_distance_mm  = dist_r;
  assign out_invalid_flag = inv_r;
  assign out_warning_flag = warn_r;
  assign out_speed_rpm    = ospeed_r;
  assign out_last_reading = last_r;

endmodule

FILE: sv/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_port_checker
// Port-level checks on the lidar packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_port_checker
  import lpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  out_angle_deg,
  input logic [13:0] out_distance_mm,
  input logic        out_invalid_flag
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_deg) && $stable(out_distance_mm))
    else $error("result beat changed while stalled");

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // angle derived from the checked index stays in range
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= 9'd359)
    else $error("angle out of range");

  // invalid readings carry the marker distance
  a_bad_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |-> out_distance_mm == BAD_DISTANCE)
    else $error("invalid reading without marker distance");

endmodule

bind lidar_packet_decoder lpd_port_checker u_lpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_angle_deg    (out_angle_deg),
  .out_distance_mm  (out_distance_mm),
  .out_invalid_flag (out_invalid_flag)
);
